// ----- rtl/pih_pkg.sv -----
// ----------------------------------------------------------------------------
// pih_pkg: shared definitions for the point-in-hexahedron test
// Coordinate and datapath widths, action codes and the fixed table of the
// twelve corner triangles that tile the element surface.
// ----------------------------------------------------------------------------
package pih_pkg;

	localparam int COORD_BITS   = 16;
	localparam int DIMENSIONS   = 3;
	localparam int FACE_COUNT   = 12;
	localparam int CORNER_COUNT = 8;

	localparam int CORNER_IDX_BITS = $clog2(CORNER_COUNT);
	localparam int FACE_IDX_BITS   = $clog2(FACE_COUNT);
	localparam int CORNER_BITS     = DIMENSIONS * COORD_BITS;

	// Edge vectors, cross-product terms, normal, scaled centroid vector,
	// dot-product terms and the dot-product accumulator.
	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int CROSS_BITS = 2 * EDGE_BITS;
	localparam int NORM_BITS  = CROSS_BITS + 1;
	localparam int CENT_BITS  = COORD_BITS + 3;
	localparam int PROD_BITS  = NORM_BITS + CENT_BITS;
	localparam int ACC_BITS   = PROD_BITS + 2;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CORNER_IDX_BITS-1:0]   corner_idx_t;
	typedef logic [FACE_IDX_BITS-1:0]     face_idx_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} corner_t;

	typedef struct packed {
		corner_idx_t v1;
		corner_idx_t v2;
		corner_idx_t v3;
	} tri_t;

	// Corner triangles of the element, wound so that the normal
	// (v2-v1)x(v2-v3) points out of the element.
	function automatic tri_t tri_corners(face_idx_t face);
		tri_t t;
		case (face)
			4'd0:    t = '{3'd0, 3'd1, 3'd2};
			4'd1:    t = '{3'd2, 3'd3, 3'd0};
			4'd2:    t = '{3'd6, 3'd5, 3'd4};
			4'd3:    t = '{3'd4, 3'd7, 3'd6};
			4'd4:    t = '{3'd5, 3'd1, 3'd0};
			4'd5:    t = '{3'd0, 3'd4, 3'd5};
			4'd6:    t = '{3'd6, 3'd7, 3'd3};
			4'd7:    t = '{3'd3, 3'd2, 3'd6};
			4'd8:    t = '{3'd1, 3'd5, 3'd6};
			4'd9:    t = '{3'd6, 3'd2, 3'd1};
			4'd10:   t = '{3'd7, 3'd4, 3'd0};
			4'd11:   t = '{3'd0, 3'd3, 3'd7};
			default: t = '{3'd0, 3'd0, 3'd0};
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/pih_if.sv -----
// ----------------------------------------------------------------------------
// pih channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pih_item_if;
	logic                valid;
	logic                ready;
	logic                action;
	pih_pkg::corner_idx_t vertex_index;
	pih_pkg::coord_t     coord_x;
	pih_pkg::coord_t     coord_y;
	pih_pkg::coord_t     coord_z;

	modport source (output valid, action, vertex_index, coord_x, coord_y, coord_z,
		input ready);
	modport sink (input valid, action, vertex_index, coord_x, coord_y, coord_z,
		output ready);
endinterface

interface pih_result_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

// ----- rtl/point_in_hexahedron_test_top.sv -----
// ----------------------------------------------------------------------------
// point_in_hexahedron_test_top: point-in-hexahedron test
// A load transaction is accepted while the sequencer is idle and gives no
// result. A test transaction checks the corner triangles in order and stops
// at the first one that rejects the point; an inside point checks all twelve.
// Each triangle uses the single shared multiplier (nine products a triangle)
// and the one read port of the corner memory. Reset clears the sequencer and
// the result register; the corner memory holds nothing until it is loaded.
// ----------------------------------------------------------------------------
module point_in_hexahedron_test_top (
	input  logic       clk,
	input  logic       arst_n,
	pih_item_if.sink   item,
	pih_result_if.source result
);

	localparam int EW = pih_pkg::EDGE_BITS;
	localparam int MW = pih_pkg::CROSS_BITS;
	localparam int NW = pih_pkg::NORM_BITS;
	localparam int CW = pih_pkg::CENT_BITS;
	localparam int PW = pih_pkg::PROD_BITS;
	localparam int AW = pih_pkg::ACC_BITS;

	// Sequencer states. Each triangle walks from ST_RD1 to ST_D2.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD1  = 4'd1;
	localparam logic [3:0] ST_RD2  = 4'd2;
	localparam logic [3:0] ST_RD3  = 4'd3;
	localparam logic [3:0] ST_EDGE = 4'd4;
	localparam logic [3:0] ST_NX0  = 4'd5;
	localparam logic [3:0] ST_NX1  = 4'd6;
	localparam logic [3:0] ST_NY0  = 4'd7;
	localparam logic [3:0] ST_NY1  = 4'd8;
	localparam logic [3:0] ST_NZ0  = 4'd9;
	localparam logic [3:0] ST_NZ1  = 4'd10;
	localparam logic [3:0] ST_D0   = 4'd11;
	localparam logic [3:0] ST_D1   = 4'd12;
	localparam logic [3:0] ST_D2   = 4'd13;
	localparam logic [3:0] ST_DONE = 4'd14;

	localparam pih_pkg::face_idx_t LAST_FACE =
		pih_pkg::FACE_IDX_BITS'(pih_pkg::FACE_COUNT - 1);

	logic [3:0]           state_q;
	pih_pkg::face_idx_t   face_q;
	logic                 inside_q;
	logic                 res_valid_q;
	logic                 res_bit_q;

	// Corner memory: written by load transactions, read one corner a cycle.
	pih_pkg::corner_t     corner_mem [pih_pkg::CORNER_COUNT];
	pih_pkg::corner_t     rd_q;
	pih_pkg::corner_idx_t rd_addr;
	pih_pkg::tri_t        tri_cur;

	// Test point and per-triangle datapath registers.
	pih_pkg::corner_t     p_q;
	pih_pkg::corner_t     v1_q;
	pih_pkg::corner_t     v2_q;
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [CW-1:0] c_q [3];
	logic signed [NW-1:0] n_q [3];
	logic signed [MW-1:0] tmp_q;
	logic signed [AW-1:0] acc_q;

	logic                 item_acc;
	logic                 start_test;
	logic                 mem_we;
	logic signed [NW-1:0] mul_a;
	logic signed [CW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] dot_sum;
	logic                 out_free;

	assign item.ready   = (state_q == ST_IDLE);
	assign item_acc     = item.valid && item.ready;
	assign start_test   = item_acc && (item.action == pih_pkg::ACT_TEST);
	assign mem_we       = item_acc && (item.action == pih_pkg::ACT_LOAD);

	assign result.valid      = res_valid_q;
	assign result.inside_res = res_bit_q;
	assign out_free          = !res_valid_q || result.ready;

	// The triangle's three corners are fetched in order through the one port.
	assign tri_cur = pih_pkg::tri_corners(face_q);

	always_comb begin
		case (state_q)
			ST_RD2:  rd_addr = tri_cur.v2;
			ST_RD3:  rd_addr = tri_cur.v3;
			default: rd_addr = tri_cur.v1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			corner_mem[item.vertex_index] <= '{item.coord_x, item.coord_y, item.coord_z};
		end
		rd_q <= corner_mem[rd_addr];
	end

	// Shared signed multiplier. The cross-product states feed it edge
	// components; the dot-product states feed it normal and centroid terms.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_NX0: begin
				mul_a = NW'(e1_q[1]);
				mul_b = CW'(e2_q[2]);
			end
			ST_NX1: begin
				mul_a = NW'(e1_q[2]);
				mul_b = CW'(e2_q[1]);
			end
			ST_NY0: begin
				mul_a = NW'(e1_q[2]);
				mul_b = CW'(e2_q[0]);
			end
			ST_NY1: begin
				mul_a = NW'(e1_q[0]);
				mul_b = CW'(e2_q[2]);
			end
			ST_NZ0: begin
				mul_a = NW'(e1_q[0]);
				mul_b = CW'(e2_q[1]);
			end
			ST_NZ1: begin
				mul_a = NW'(e1_q[1]);
				mul_b = CW'(e2_q[0]);
			end
			ST_D0: begin
				mul_a = n_q[0];
				mul_b = c_q[0];
			end
			ST_D1: begin
				mul_a = n_q[1];
				mul_b = c_q[1];
			end
			ST_D2: begin
				mul_a = n_q[2];
				mul_b = c_q[2];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign dot_sum = acc_q + AW'(prod);

	// Datapath registers. They carry no reset; the sequencer qualifies them.
	always_ff @(posedge clk) begin
		if (start_test) begin
			p_q <= '{item.coord_x, item.coord_y, item.coord_z};
		end
		case (state_q)
			ST_RD2: v1_q <= rd_q;
			ST_RD3: v2_q <= rd_q;
			ST_EDGE: begin
				// Edges share v2; the centroid vector is kept scaled by three.
				e1_q[0] <= EW'(v2_q.x) - EW'(v1_q.x);
				e1_q[1] <= EW'(v2_q.y) - EW'(v1_q.y);
				e1_q[2] <= EW'(v2_q.z) - EW'(v1_q.z);
				e2_q[0] <= EW'(v2_q.x) - EW'(rd_q.x);
				e2_q[1] <= EW'(v2_q.y) - EW'(rd_q.y);
				e2_q[2] <= EW'(v2_q.z) - EW'(rd_q.z);
				c_q[0]  <= CW'(v1_q.x) + CW'(v2_q.x) + CW'(rd_q.x)
					- ((CW'(p_q.x) <<< 1) + CW'(p_q.x));
				c_q[1]  <= CW'(v1_q.y) + CW'(v2_q.y) + CW'(rd_q.y)
					- ((CW'(p_q.y) <<< 1) + CW'(p_q.y));
				c_q[2]  <= CW'(v1_q.z) + CW'(v2_q.z) + CW'(rd_q.z)
					- ((CW'(p_q.z) <<< 1) + CW'(p_q.z));
			end
			ST_NX0, ST_NY0, ST_NZ0: tmp_q <= MW'(prod);
			ST_NX1: n_q[0] <= NW'(tmp_q) - NW'(prod);
			ST_NY1: n_q[1] <= NW'(tmp_q) - NW'(prod);
			ST_NZ1: n_q[2] <= NW'(tmp_q) - NW'(prod);
			ST_D0:  acc_q <= AW'(prod);
			ST_D1:  acc_q <= dot_sum;
			default: begin
			end
		endcase
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			face_q      <= '0;
			inside_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_bit_q   <= 1'b0;
		end else begin
			// The done state refills the register itself when the old result leaves.
			if (res_valid_q && result.ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_test) begin
						face_q  <= '0;
						state_q <= ST_RD1;
					end
				end
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_RD3;
				ST_RD3:  state_q <= ST_EDGE;
				ST_EDGE: state_q <= ST_NX0;
				ST_NX0:  state_q <= ST_NX1;
				ST_NX1:  state_q <= ST_NY0;
				ST_NY0:  state_q <= ST_NY1;
				ST_NY1:  state_q <= ST_NZ0;
				ST_NZ0:  state_q <= ST_NZ1;
				ST_NZ1:  state_q <= ST_D0;
				ST_D0:   state_q <= ST_D1;
				ST_D1:   state_q <= ST_D2;
				ST_D2: begin
					// A negative dot product puts the point outside; zero is inside.
					if (dot_sum[AW-1]) begin
						inside_q <= 1'b0;
						state_q  <= ST_DONE;
					end else if (face_q == LAST_FACE) begin
						inside_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						face_q  <= face_q + 1'b1;
						state_q <= ST_RD1;
					end
				end
				ST_DONE: begin
					// Wait here if the previous result has not been taken yet.
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_bit_q   <= inside_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// The face counter never runs past the last triangle.
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		face_q <= LAST_FACE)
		else $error("face counter out of range");

	// A test transaction starts the triangle walk on the next cycle.
	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start_test |=> (state_q == ST_RD1 && face_q == '0))
		else $error("test transaction did not start the sequencer");

	// A load transaction leaves the sequencer idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == ST_IDLE))
		else $error("load transaction disturbed the sequencer");

	// Leaving the done state always presents a result.
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free)
		|=> (result.valid && result.inside_res == $past(inside_q)))
		else $error("finished test did not present its result");
`endif

endmodule
